FILE: design/tpf_pkg.sv
`timescale 1ns / 1ps
package tpf_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int HDR_LEN_W       = 24;
	localparam int CMDQ_DEPTH      = 4;
	localparam int OUTQ_DEPTH      = 4;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] PAD_BYTE0 = 8'd55;
	localparam logic [7:0] PAD_BYTE1 = 8'd66;
	localparam logic [7:0] PAD_BYTE2 = 8'd77;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	typedef enum logic [1:0] {
		ROLE_HEADER  = 2'd0,
		ROLE_PAYLOAD = 2'd1,
		ROLE_CRC     = 2'd2,
		ROLE_PAD     = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_MISUSE = 2'd2
	} cmd_kind_t;

	// last: on a start, the length is zero; on data, this byte closes the packet
	typedef struct packed {
		cmd_kind_t   kind;
		logic        last;
		logic [7:0]  data;
		logic [7:0]  id;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		role_t      role;
		logic       misuse;
		logic       last;
	} result_t;

	// Augmented CRC step over one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			c = {c[14:0], b[i]} ^ (c[15] ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

endpackage

FILE: design/tx_packet_framer_crc16_core.sv
`timescale 1ns / 1ps
// Transmit packet framer with CRC-16 (poly 0x1021, init 0xFFFF, augmented).
// Input channel (push/full): a start item (kind 0) opens a packet and yields
// the header (length low byte first, then the id); a payload item (kind 1)
// yields its byte. After the last payload byte, or right after the header
// for a zero length, the block appends the CRC (high byte first) and the
// pads 55, 66, 77. A payload item with no packet open yields one flagged
// result and is dropped. A start while a packet is open abandons it.
// Result channel (empty/pop): the oldest result sits on the ports while
// empty is low; last_of_run marks the final result of each input item.
// An accepted item passes the command queue, then the back-end sequencer,
// which writes its results to the result queue. Throughput: one payload item
// per cycle while the result queue has room; a start item sends four header
// bytes, closing a packet adds a CRC augmentation step, 2 CRC bytes, 3 pads.
// The back end sets the rate: one byte, one CRC step per cycle unless stalled.
// A stalled receiver fills the result queue, then the command queue, then
// raises full. Reset clears both queues, closes any packet and restores
// the CRC to 0xFFFF.
module tx_packet_framer_crc16_core #(
	parameter int LENGTH_BITS = tpf_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [23:0] payload_length,
	input  logic [7:0]  packet_id,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_role,
	output logic        misuse_flag,
	output logic        last_of_run
);

	localparam int CMD_W = $bits(tpf_pkg::cmd_t) + LENGTH_BITS;
	localparam int RES_W = $bits(tpf_pkg::result_t);

	// Front end: classify each transaction and hand it over as a command.
	logic                   cmd_wr;
	tpf_pkg::cmd_t          cmd_in;
	logic [LENGTH_BITS-1:0] cmd_len_in;

	tpf_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_full        (full),
		.kind          (kind),
		.payload_length(payload_length),
		.packet_id     (packet_id),
		.data_byte     (data_byte),
		.cmd_wr        (cmd_wr),
		.cmd           (cmd_in),
		.cmd_len       (cmd_len_in)
	);

	// Command queue: decouple acceptance from byte sequencing.
	logic [CMD_W-1:0]       cmd_rd_data;
	logic                   cmd_empty;
	logic                   cmd_pop;
	tpf_pkg::cmd_t          cmd_out;
	logic [LENGTH_BITS-1:0] cmd_len_out;

	tpf_fifo #(
		.DEPTH(tpf_pkg::CMDQ_DEPTH),
		.WIDTH(CMD_W)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_wr),
		.wr_data({cmd_in, cmd_len_in}),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rd_data),
		.empty  (cmd_empty)
	);

	assign cmd_out     = tpf_pkg::cmd_t'(cmd_rd_data[CMD_W-1:LENGTH_BITS]);
	assign cmd_len_out = cmd_rd_data[LENGTH_BITS-1:0];

	// Back end: sequence header, payload, CRC and pad bytes.
	logic             out_full;
	logic             out_push;
	tpf_pkg::result_t res_in;

	tpf_back #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_len  (cmd_len_out),
		.cmd_pop  (cmd_pop),
		.out_full (out_full),
		.out_push (out_push),
		.res      (res_in)
	);

	// Result queue: hold finished bytes while the receiver stalls.
	logic [RES_W-1:0] res_rd_data;
	tpf_pkg::result_t res_out;

	tpf_fifo #(
		.DEPTH(tpf_pkg::OUTQ_DEPTH),
		.WIDTH(RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_push),
		.wr_data(res_in),
		.full   (out_full),
		.rd_en  (pop),
		.rd_data(res_rd_data),
		.empty  (empty)
	);

	assign res_out     = tpf_pkg::result_t'(res_rd_data);
	assign out_byte    = res_out.out_byte;
	assign byte_role   = res_out.role;
	assign misuse_flag = res_out.misuse;
	assign last_of_run = res_out.last;

endmodule

FILE: design/tpf_fifo.sv
`timescale 1ns / 1ps
module tpf_fifo #(
	parameter int DEPTH = tpf_pkg::CMDQ_DEPTH,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({wr_fire, rd_fire})
				2'b10: begin
					count_q <= CNT_W'(count_q + 1'b1);
				end
				2'b01: begin
					count_q <= CNT_W'(count_q - 1'b1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

FILE: design/tpf_front.sv
`timescale 1ns / 1ps
module tpf_front #(
	parameter int LENGTH_BITS = tpf_pkg::LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   q_full,
	input  logic                   kind,
	input  logic [23:0]            payload_length,
	input  logic [7:0]             packet_id,
	input  logic [7:0]             data_byte,
	output logic                   cmd_wr,
	output tpf_pkg::cmd_t          cmd,
	output logic [LENGTH_BITS-1:0] cmd_len
);

	// Packet bookkeeping follows the input stream alone, so track it here.
	logic                   open_q;
	logic [LENGTH_BITS-1:0] remaining_q;
	logic [LENGTH_BITS-1:0] len;
	logic                   len_zero;
	logic                   data_last;

	assign cmd_wr    = push && !q_full;
	assign len       = payload_length[LENGTH_BITS-1:0];
	assign len_zero  = (len == '0);
	assign data_last = (remaining_q == LENGTH_BITS'(1));
	assign cmd_len   = len;

	always_comb begin
		cmd.data = data_byte;
		cmd.id   = packet_id;
		if (kind == tpf_pkg::KIND_START) begin
			cmd.kind = tpf_pkg::CMD_START;
			cmd.last = len_zero;
		end else if (open_q) begin
			cmd.kind = tpf_pkg::CMD_DATA;
			cmd.last = data_last;
		end else begin
			cmd.kind = tpf_pkg::CMD_MISUSE;
			cmd.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			remaining_q <= '0;
		end else if (cmd_wr) begin
			if (kind == tpf_pkg::KIND_START) begin
				open_q      <= !len_zero;
				remaining_q <= len;
			end else if (open_q) begin
				remaining_q <= LENGTH_BITS'(remaining_q - 1'b1);
				if (data_last) begin
					open_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: design/tpf_back.sv
`timescale 1ns / 1ps
module tpf_back #(
	parameter int LENGTH_BITS = tpf_pkg::LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_empty,
	input  tpf_pkg::cmd_t          cmd,
	input  logic [LENGTH_BITS-1:0] cmd_len,
	output logic                   cmd_pop,
	input  logic                   out_full,
	output logic                   out_push,
	output tpf_pkg::result_t       res
);

	typedef enum logic [5:0] {
		ST_FETCH = 6'b000001,
		ST_HDR   = 6'b000010,
		ST_AUG   = 6'b000100,
		ST_CRCH  = 6'b001000,
		ST_CRCL  = 6'b010000,
		ST_PAD   = 6'b100000
	} state_t;

	state_t      state_q, state_d;
	logic [1:0]  idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] len_hi_q, len_hi_d;
	logic [7:0]  id_q, id_d;
	logic        zero_q, zero_d;

	logic [tpf_pkg::HDR_LEN_W-1:0] len_ext;
	logic [7:0]                    hdr_byte;
	logic [7:0]                    pad_byte;
	logic [15:0]                   crc_zero;
	logic                          can_emit;

	assign len_ext  = tpf_pkg::HDR_LEN_W'(cmd_len);
	assign crc_zero = tpf_pkg::crc_byte(crc_q, 8'h00);
	assign can_emit = !out_full;

	always_comb begin
		case (idx_q)
			2'd1:    hdr_byte = len_hi_q[7:0];
			2'd2:    hdr_byte = len_hi_q[15:8];
			default: hdr_byte = id_q;
		endcase
		case (idx_q)
			2'd0:    pad_byte = tpf_pkg::PAD_BYTE0;
			2'd1:    pad_byte = tpf_pkg::PAD_BYTE1;
			default: pad_byte = tpf_pkg::PAD_BYTE2;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		crc_d        = crc_q;
		len_hi_d     = len_hi_q;
		id_d         = id_q;
		zero_d       = zero_q;
		cmd_pop      = 1'b0;
		out_push     = 1'b0;
		res.out_byte = 8'h00;
		res.role     = tpf_pkg::ROLE_PAYLOAD;
		res.misuse   = 1'b0;
		res.last     = 1'b0;
		case (state_q)
			ST_FETCH: begin
				if (!cmd_empty && can_emit) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						tpf_pkg::CMD_MISUSE: begin
							out_push   = 1'b1;
							res.misuse = 1'b1;
							res.last   = 1'b1;
						end
						tpf_pkg::CMD_DATA: begin
							out_push     = 1'b1;
							res.out_byte = cmd.data;
							res.last     = !cmd.last;
							crc_d        = tpf_pkg::crc_byte(crc_q, cmd.data);
							if (cmd.last) begin
								state_d = ST_AUG;
							end
						end
						tpf_pkg::CMD_START: begin
							// A start abandons any open packet: restart the CRC.
							out_push     = 1'b1;
							res.out_byte = len_ext[7:0];
							res.role     = tpf_pkg::ROLE_HEADER;
							crc_d        = tpf_pkg::crc_byte(tpf_pkg::CRC_INIT, len_ext[7:0]);
							len_hi_d     = len_ext[23:8];
							id_d         = cmd.id;
							zero_d       = cmd.last;
							idx_d        = 2'd1;
							state_d      = ST_HDR;
						end
						default: begin
							out_push = 1'b0;
						end
					endcase
				end
			end
			ST_HDR: begin
				if (can_emit) begin
					out_push     = 1'b1;
					res.out_byte = hdr_byte;
					res.role     = tpf_pkg::ROLE_HEADER;
					crc_d        = tpf_pkg::crc_byte(crc_q, hdr_byte);
					if (idx_q == 2'd3) begin
						res.last = !zero_q;
						state_d  = zero_q ? ST_AUG : ST_FETCH;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			ST_AUG: begin
				// First eight of the sixteen appended zero bits.
				crc_d   = crc_zero;
				state_d = ST_CRCH;
			end
			ST_CRCH: begin
				if (can_emit) begin
					out_push     = 1'b1;
					res.out_byte = crc_zero[15:8];
					res.role     = tpf_pkg::ROLE_CRC;
					crc_d        = crc_zero;
					state_d      = ST_CRCL;
				end
			end
			ST_CRCL: begin
				if (can_emit) begin
					out_push     = 1'b1;
					res.out_byte = crc_q[7:0];
					res.role     = tpf_pkg::ROLE_CRC;
					idx_d        = 2'd0;
					state_d      = ST_PAD;
				end
			end
			ST_PAD: begin
				if (can_emit) begin
					out_push     = 1'b1;
					res.out_byte = pad_byte;
					res.role     = tpf_pkg::ROLE_PAD;
					if (idx_q == 2'd2) begin
						res.last = 1'b1;
						crc_d    = tpf_pkg::CRC_INIT;
						state_d  = ST_FETCH;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			default: begin
				state_d = ST_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
			idx_q   <= 2'd0;
			crc_q   <= tpf_pkg::CRC_INIT;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		len_hi_q <= len_hi_d;
		id_q     <= id_d;
		zero_q   <= zero_d;
	end

endmodule

FILE: sim/tx_packet_framer_crc16_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the transmit packet framer: a queue of pending
// input transactions feeds a bursty driver, a scoreboard of predicted bytes
// is filled as each transaction is accepted, and a monitor checks every
// popped result against the oldest prediction.
module tx_packet_framer_crc16_core_tb;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 240;
	localparam int DRAIN_CYCLES = 20;

	// One input transaction as presented on the push side.
	typedef struct packed {
		logic        kind;
		logic [23:0] len;
		logic [7:0]  id;
		logic [7:0]  data;
	} frame_item_t;

	// One predicted byte of the transmit stream.
	typedef struct packed {
		logic [7:0]      value;
		tpf_pkg::role_t  role;
		logic            misuse;
		logic            last;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        kind = 1'b0;
	logic [23:0] payload_length = '0;
	logic [7:0]  packet_id = '0;
	logic [7:0]  data_byte = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic [1:0]  byte_role;
	logic        misuse_flag;
	logic        last_of_run;

	frame_item_t pending_items[$];
	frame_byte_t tx_expect[$];

	// Predictor state: running CRC, bytes still owed, packet open flag.
	logic [15:0] crc_acc = tpf_pkg::CRC_INIT;
	logic [23:0] bytes_owed = '0;
	logic        pkt_open = 1'b0;

	// Handshake bookkeeping between the sampling and driving edges.
	int n_taken = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rx_stall = 0;
	logic [7:0] rx_pattern = 8'hFF;
	logic [2:0] rx_phase = '0;

	int idle_cycles = 0;
	int n_errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_closed = 0;
	int n_misuse = 0;
	int n_abandoned = 0;

	tx_packet_framer_crc16_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.payload_length (payload_length),
		.packet_id      (packet_id),
		.data_byte      (data_byte),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.byte_role      (byte_role),
		.misuse_flag    (misuse_flag),
		.last_of_run    (last_of_run)
	);

	always #2 clk = ~clk;

	// Shift one byte through the augmented CRC-16 register, MSB first.
	function automatic logic [15:0] crc_shift_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15];
			r = {r[14:0], b[i]};
			if (fb)
				r = r ^ tpf_pkg::CRC_POLY;
		end
		return r;
	endfunction

	task automatic queue_byte(input logic [7:0] v, input tpf_pkg::role_t r, input logic m);
		frame_byte_t fb;
		fb.value  = v;
		fb.role   = r;
		fb.misuse = m;
		fb.last   = 1'b0;
		tx_expect.push_back(fb);
	endtask

	// Append the 16 zero bits, emit CRC high byte first, then the pads.
	task automatic close_frame();
		logic [15:0] c;
		c = crc_shift_byte(crc_shift_byte(crc_acc, 8'h00), 8'h00);
		queue_byte(c[15:8], tpf_pkg::ROLE_CRC, 1'b0);
		queue_byte(c[7:0], tpf_pkg::ROLE_CRC, 1'b0);
		queue_byte(tpf_pkg::PAD_BYTE0, tpf_pkg::ROLE_PAD, 1'b0);
		queue_byte(tpf_pkg::PAD_BYTE1, tpf_pkg::ROLE_PAD, 1'b0);
		queue_byte(tpf_pkg::PAD_BYTE2, tpf_pkg::ROLE_PAD, 1'b0);
		crc_acc = tpf_pkg::CRC_INIT;
		bytes_owed = '0;
		pkt_open = 1'b0;
		n_closed++;
	endtask

	// Work out every byte that one accepted transaction causes.
	task automatic predict_frame_bytes(input frame_item_t it);
		logic [7:0] hdr [4];
		if (it.kind == tpf_pkg::KIND_START) begin
			if (pkt_open)
				n_abandoned++;
			hdr[0] = it.len[7:0];
			hdr[1] = it.len[15:8];
			hdr[2] = it.len[23:16];
			hdr[3] = it.id;
			crc_acc = tpf_pkg::CRC_INIT;
			for (int i = 0; i < 4; i++) begin
				crc_acc = crc_shift_byte(crc_acc, hdr[i]);
				queue_byte(hdr[i], tpf_pkg::ROLE_HEADER, 1'b0);
			end
			bytes_owed = it.len;
			pkt_open = 1'b1;
			if (it.len == '0)
				close_frame();
		end else if (!pkt_open) begin
			// Drop a stray payload byte: flag it, leave the CRC alone.
			queue_byte(8'h00, tpf_pkg::ROLE_PAYLOAD, 1'b1);
			n_misuse++;
		end else begin
			crc_acc = crc_shift_byte(crc_acc, it.data);
			queue_byte(it.data, tpf_pkg::ROLE_PAYLOAD, 1'b0);
			bytes_owed = bytes_owed - 24'd1;
			if (bytes_owed == '0)
				close_frame();
		end
		tx_expect[tx_expect.size() - 1].last = 1'b1;
	endtask

	// Fill the fields that the block ignores with noise.
	task automatic add_start(input logic [23:0] len, input logic [7:0] id);
		frame_item_t it;
		it.kind = tpf_pkg::KIND_START;
		it.len  = len;
		it.id   = id;
		it.data = 8'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic add_data(input logic [7:0] b);
		frame_item_t it;
		it.kind = tpf_pkg::KIND_DATA;
		it.len  = 24'($urandom);
		it.id   = 8'($urandom);
		it.data = b;
		pending_items.push_back(it);
	endtask

	task automatic check_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, what, exp_v, act_v);
			n_errors++;
		end
	endtask

	// Sample both handshakes at the rising edge; ports were driven on the
	// falling edge, so the values read here are settled.
	always @(posedge clk) begin : observe
		frame_item_t it;
		frame_byte_t fb;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			// Predict first so an input and an output on one edge stay ordered.
			if (push && !full) begin
				it.kind = kind;
				it.len  = payload_length;
				it.id   = packet_id;
				it.data = data_byte;
				predict_frame_bytes(it);
				n_items++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				n_results++;
				if (tx_expect.size() == 0) begin
					$display("%0t: result with nothing expected: expected none actual byte %0h role %0d",
						$time, out_byte, byte_role);
					n_errors++;
				end else begin
					fb = tx_expect.pop_front();
					check_field("out_byte", fb.value, out_byte);
					check_field("byte_role", fb.role, byte_role);
					check_field("misuse_flag", fb.misuse, misuse_flag);
					check_field("last_of_run", fb.last, last_of_run);
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Push side: present the head of the pending queue in bursts, hold it
	// while full is high, and insert random gaps after a burst ends.
	always @(negedge clk) begin : drive_push
		frame_item_t it;
		logic nxt_push;
		nxt_push = 1'b0;
		if (arst_n) begin
			if (n_items != n_taken) begin
				pending_items.pop_front();
				n_taken++;
				burst_left--;
				if (burst_left <= 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					burst_left = $urandom_range(1, 16);
				end
			end
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				it = pending_items[0];
				kind           <= it.kind;
				payload_length <= it.len;
				packet_id      <= it.id;
				data_byte      <= it.data;
				nxt_push = 1'b1;
			end
		end
		push <= nxt_push;
	end

	// Pop side: walk an 8-bit stall pattern, reload it after each pass through its bits,
	// and now and then hold off for a long stretch to back up both queues.
	always @(negedge clk) begin : drive_pop
		logic nxt_pop;
		nxt_pop = 1'b0;
		if (arst_n) begin
			if (rx_stall > 0) begin
				rx_stall--;
			end else begin
				nxt_pop = rx_pattern[rx_phase];
				rx_phase = rx_phase + 3'd1;
				if (rx_phase == '0) begin
					case ($urandom_range(0, 3))
						0: rx_pattern = 8'hFF;
						1: rx_pattern = 8'b1001_0010;
						default: rx_pattern = 8'($urandom) | 8'h01;
					endcase
					if ($urandom_range(0, 15) == 0)
						rx_stall = $urandom_range(5, 40);
				end
			end
		end
		pop <= nxt_pop;
	end

	// End the run if nothing moves on either side for too long.
	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int target;
		int sel;
		int len;
		int n;

		// Directed: misuse straight out of reset, both data extremes.
		add_data(8'hFF);
		add_data(8'h00);
		// Zero length closes at once, id extremes.
		add_start(24'h000000, 8'h00);
		add_start(24'h000000, 8'hFF);
		// Largest length, then abandon it with a one-byte packet.
		add_start(24'hFFFFFF, 8'hA5);
		add_data(8'h7E);
		add_start(24'h000001, 8'h5A);
		add_data(8'hFF);
		add_start(24'h000002, 8'h3C);
		add_data(8'h00);
		add_data(8'h80);
		// Stray byte after a clean close.
		add_data(8'h12);
		// Alternating length bits, each abandoned by the next start.
		add_start(24'hAAAAAA, 8'h55);
		add_start(24'h555555, 8'hAA);
		add_data(8'h01);
		add_start(24'h800000, 8'h01);
		add_start(24'h000003, 8'h02);
		add_data(8'h01);
		add_data(8'h02);
		add_data(8'h03);
		add_start(24'h000000, 8'h81);

		// Random: mostly complete packets, some stray bytes and cut-off packets.
		target = pending_items.size() + RANDOM_ITEMS;
		while (pending_items.size() < target) begin
			sel = $urandom_range(0, 9);
			if (sel <= 6) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				add_start(24'(len), 8'($urandom));
				repeat (len) add_data(8'($urandom));
			end else if (sel == 7) begin
				repeat ($urandom_range(1, 3)) add_data(8'($urandom));
			end else if (sel == 8) begin
				// Full-width random length, only a few bytes supplied.
				add_start(24'($urandom), 8'($urandom));
				repeat ($urandom_range(0, 3)) add_data(8'($urandom));
			end else begin
				len = $urandom_range(1, 8);
				n = $urandom_range(0, len - 1);
				add_start(24'(len), 8'($urandom));
				repeat (n) add_data(8'($urandom));
			end
		end

		// Hold reset, then release it on a falling edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the pending queue and the scoreboard to drain.
		do
			@(negedge clk);
		while (pending_items.size() != 0 || tx_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Accepted %0d input transactions and checked %0d output bytes:", n_items, n_results);
		$display("%0d packets closed, %0d abandoned, %0d stray payload bytes flagged",
			n_closed, n_abandoned, n_misuse);
		if (n_errors == 0 && tx_expect.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
design/tpf_pkg.sv
design/tpf_fifo.sv
design/tpf_front.sv
design/tpf_back.sv
design/tx_packet_framer_crc16_core.sv
sim/tx_packet_framer_crc16_core_tb.sv
